>>> rtl/core/tesp_pkg.sv
// Shared types and constants of the terminal escape sequence parser.
`timescale 1ns / 1ps
`default_nettype none

package tesp_pkg;

   // Result actions.
   localparam logic [3:0] ACT_WRITE_CHAR  = 4'd0;
   localparam logic [3:0] ACT_MOVE_REL    = 4'd1;
   localparam logic [3:0] ACT_MOVE_ABS    = 4'd2;
   localparam logic [3:0] ACT_RESET_COLOR = 4'd3;
   localparam logic [3:0] ACT_FG          = 4'd4;
   localparam logic [3:0] ACT_BG          = 4'd5;
   localparam logic [3:0] ACT_REPORT_POS  = 4'd6;
   localparam logic [3:0] ACT_FULL_AREA   = 4'd7;
   localparam logic [3:0] ACT_SET_AREA    = 4'd8;
   localparam logic [3:0] ACT_SCROLL      = 4'd9;
   localparam logic [3:0] ACT_INPUT_MODE  = 4'd10;
   localparam logic [3:0] ACT_ECHO        = 4'd11;
   localparam logic [3:0] ACT_REPORT_SIZE = 4'd12;
   localparam logic [3:0] ACT_PROCESS     = 4'd13;

   // Bytes with a meaning of their own.
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_ESC      = 8'd27;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;

   // VT100 final bytes.
   localparam logic [7:0] VT_UP        = 8'h41;
   localparam logic [7:0] VT_DOWN      = 8'h42;
   localparam logic [7:0] VT_RIGHT     = 8'h43;
   localparam logic [7:0] VT_LEFT      = 8'h44;
   localparam logic [7:0] VT_SCROLL_UP = 8'h53;
   localparam logic [7:0] VT_SCROLL_DN = 8'h54;
   localparam logic [7:0] VT_POS       = 8'h66;
   localparam logic [7:0] VT_COLOR     = 8'h6D;
   localparam logic [7:0] VT_QUERY     = 8'h6E;
   localparam logic [7:0] VT_AREA      = 8'h72;

   // Private final bytes.
   localparam logic [7:0] PV_PROC = 8'h63;
   localparam logic [7:0] PV_ECHO = 8'h65;
   localparam logic [7:0] PV_SIZE = 8'h69;
   localparam logic [7:0] PV_MODE = 8'h6D;
   localparam logic [7:0] PV_PUTC = 8'h70;

   localparam logic [15:0] FG_BASE   = 16'd30;
   localparam logic [15:0] BG_BASE   = 16'd40;
   localparam logic [15:0] COLOR_END = 16'd50;
   localparam logic [15:0] QUERY_POS = 16'd6;
   localparam logic [2:0]  COLOR_WHITE = 3'd7;

   localparam int MAX_RESULTS = 8;
   localparam int EW          = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH = 2;

   // One command handed from the front to the back.
   typedef struct packed {
      logic               colour;     // expand the stored parameters of an 'm'
      logic [1:0]         rep;        // extra copies of a single result
      logic [3:0]         action;
      logic [7:0]         char_code;
      logic               highlight;
      logic signed [16:0] value_a;
      logic signed [16:0] value_b;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/tesp_front.sv
// Front part: byte acceptance, sequence parsing and command classification.
`timescale 1ns / 1ps
`default_nettype none

module tesp_front import tesp_pkg::*; #(
   parameter int MAX_PARAMS = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [7:0]                  byte_in,
   input  wire logic                        error_stream,
   output logic                             job_valid,
   output cmd_type                          job_cmd,
   output logic [MAX_PARAMS-1:0]            job_mask,
   output logic [MAX_PARAMS-1:0][15:0]      job_vals
);

   localparam int CW = $clog2(MAX_PARAMS + 2);

   localparam logic [1:0] ST_TEXT = 2'd0;
   localparam logic [1:0] ST_ESC  = 2'd1;
   localparam logic [1:0] ST_VT   = 2'd2;
   localparam logic [1:0] ST_PRIV = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [MAX_PARAMS-1:0][15:0]  vals_ff, vals_in;

   logic [MAX_PARAMS-1:0]        mask;
   logic [15:0]                  p0, p1;
   logic [CW-1:0]                eff_count;
   logic [3:0]                   digit;
   logic                         is_digit;
   logic [19:0]                  prod;

   // Parameters that the colour command turns into results.
   always_comb begin
      for (int i = 0; i < MAX_PARAMS; i++) begin
         mask[i] = (CW'(i) < count_ff) &&
                   ((vals_ff[i] == 16'd0) ||
                    ((vals_ff[i] >= FG_BASE) && (vals_ff[i] < COLOR_END)));
      end
   end

   always_comb begin
      p0 = vals_ff[0];
      p1 = 16'd0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
         if (i == 1) begin
            p1 = vals_ff[i];
         end
      end
   end

   assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign digit     = 4'(byte_in - CH_ZERO);
   assign eff_count = (count_ff == '0) ? CW'(1) : count_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      vals_in   = vals_ff;
      job_valid = 1'b0;
      job_cmd   = '0;
      prod      = '0;
      if (accept) begin
         unique case (state_ff) inside
            ST_TEXT: begin
               if (byte_in == CH_TAB) begin
                  job_valid         = 1'b1;
                  job_cmd.rep       = 2'd3;
                  job_cmd.char_code = CH_SPACE;
               end else if (byte_in == CH_ESC) begin
                  state_in = ST_ESC;
               end else if (byte_in != CH_CR) begin
                  job_valid         = 1'b1;
                  job_cmd.char_code = byte_in;
                  job_cmd.highlight = error_stream;
               end
            end
            ST_ESC: begin
               if (byte_in == CH_LBRACKET) begin
                  state_in = ST_VT;
               end else if (byte_in == CH_LBRACE) begin
                  state_in = ST_PRIV;
               end else begin
                  state_in = ST_TEXT;
               end
            end
            ST_VT, ST_PRIV: begin
               if (is_digit) begin
                  count_in = eff_count;
                  // Only the parameter being entered takes the digit; past the
                  // last stored parameter no lane matches.
                  for (int i = 0; i < MAX_PARAMS; i++) begin
                     prod = {1'b0, vals_ff[i], 3'b000} + {3'b000, vals_ff[i], 1'b0} +
                            {16'd0, digit};
                     if (eff_count == CW'(i + 1)) begin
                        vals_in[i] = (prod[19:16] != 4'd0) ? 16'hFFFF : prod[15:0];
                     end
                  end
               end else if (byte_in == CH_SEMI) begin
                  if (count_ff <= CW'(MAX_PARAMS)) begin
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  state_in  = ST_TEXT;
                  count_in  = '0;
                  vals_in   = '0;
                  job_valid = 1'b1;
                  if (state_ff == ST_VT) begin
                     unique case (byte_in)
                        VT_UP: begin
                           job_cmd.action  = ACT_MOVE_REL;
                           job_cmd.value_b = -$signed({1'b0, p0});
                        end
                        VT_DOWN: begin
                           job_cmd.action  = ACT_MOVE_REL;
                           job_cmd.value_b = $signed({1'b0, p0});
                        end
                        VT_RIGHT: begin
                           job_cmd.action  = ACT_MOVE_REL;
                           job_cmd.value_a = $signed({1'b0, p0});
                        end
                        VT_LEFT: begin
                           job_cmd.action  = ACT_MOVE_REL;
                           job_cmd.value_a = -$signed({1'b0, p0});
                        end
                        VT_COLOR: begin
                           job_cmd.colour = 1'b1;
                           job_valid      = (mask != '0);
                        end
                        VT_POS: begin
                           job_cmd.action  = ACT_MOVE_ABS;
                           job_cmd.value_a = $signed({1'b0, p0});
                           job_cmd.value_b = $signed({1'b0, p1});
                        end
                        VT_QUERY: begin
                           job_cmd.action = ACT_REPORT_POS;
                           job_valid      = (p0 == QUERY_POS);
                        end
                        VT_AREA: begin
                           if (count_ff == '0) begin
                              job_cmd.action = ACT_FULL_AREA;
                           end else begin
                              job_cmd.action  = ACT_SET_AREA;
                              job_cmd.value_a = $signed({1'b0, p0});
                              job_cmd.value_b = $signed({1'b0, p1});
                           end
                        end
                        VT_SCROLL_UP: begin
                           job_cmd.action  = ACT_SCROLL;
                           job_cmd.value_a = $signed({1'b0, p0});
                        end
                        VT_SCROLL_DN: begin
                           job_cmd.action  = ACT_SCROLL;
                           job_cmd.value_a = -$signed({1'b0, p0});
                        end
                        default: job_valid = 1'b0;
                     endcase
                  end else begin
                     unique case (byte_in)
                        PV_MODE: begin
                           job_cmd.action  = ACT_INPUT_MODE;
                           job_cmd.value_a = $signed({1'b0, p0});
                        end
                        PV_ECHO: begin
                           job_cmd.action  = ACT_ECHO;
                           job_cmd.value_a = (p0 == 16'd1) ? 17'sd1 : 17'sd0;
                        end
                        PV_SIZE: job_cmd.action = ACT_REPORT_SIZE;
                        PV_PUTC: begin
                           job_cmd.action    = ACT_WRITE_CHAR;
                           job_cmd.char_code = p0[7:0];
                        end
                        PV_PROC: begin
                           job_cmd.action  = ACT_PROCESS;
                           job_cmd.value_a = $signed({1'b0, p0});
                        end
                        default: job_valid = 1'b0;
                     endcase
                  end
               end
            end
            default: state_in = ST_TEXT;
         endcase
      end
   end

   assign job_mask = mask;
   assign job_vals = vals_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TEXT;
         count_ff <= '0;
         vals_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vals_ff  <= vals_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tesp_queue.sv
// Short command queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module tesp_queue import tesp_pkg::*; #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head,
   output logic                  not_empty,
   output logic                  full
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [QUEUE_DEPTH-1:0][WIDTH-1:0] data_ff;
   logic [PW-1:0]                     wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0]                     fill_ff, fill_in;

   assign head      = data_ff[rd_ff];
   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == NW'(QUEUE_DEPTH));

   always_comb begin
      wr_in   = push ? ((wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1)) : wr_ff;
      rd_in   = pop  ? ((rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1)) : rd_ff;
      fill_in = fill_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tesp_back.sv
// Back part: queued commands become results, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module tesp_back import tesp_pkg::*; #(
   parameter int MAX_PARAMS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire cmd_type                       head_cmd,
   input  wire logic [MAX_PARAMS-1:0]         head_mask,
   input  wire logic [MAX_PARAMS-1:0][15:0]   head_vals,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [3:0]                         rsp_action,
   output logic [7:0]                         rsp_char_code,
   output logic                               rsp_highlight,
   output logic signed [16:0]                 rsp_value_a,
   output logic signed [16:0]                 rsp_value_b,
   output logic                               rsp_last
);

   logic                  load;
   logic [1:0]            rep_ff, rep_in;
   logic [MAX_PARAMS-1:0] done_ff, done_in;
   logic [EW-1:0]         emit_ff, emit_in;

   logic [MAX_PARAMS-1:0] live, pick, rest;
   logic [15:0]           sel_val, idx;
   logic [2:0]            color;
   logic                  last;

   logic                  valid_ff, valid_in;
   logic [3:0]            action_ff, action_in;
   logic [7:0]            char_ff, char_in;
   logic                  hl_ff, hl_in;
   logic signed [16:0]    a_ff, a_in, b_ff, b_in;
   logic                  last_ff, last_in;

   assign load = head_valid && (!valid_ff || !rsp_stall);

   // Lowest parameter of the colour command still to be handled.
   assign live = head_mask & ~done_ff;
   assign pick = live & (~live + MAX_PARAMS'(1));
   assign rest = live & ~pick;

   always_comb begin
      sel_val = '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
         sel_val = sel_val | (pick[i] ? head_vals[i] : 16'd0);
      end
   end

   assign idx   = (sel_val < BG_BASE) ? sel_val - FG_BASE : sel_val - BG_BASE;
   assign color = (idx[3:0] >= 4'd8) ? COLOR_WHITE : idx[2:0];

   always_comb begin
      if (head_cmd.colour) begin
         last = (rest == '0) || (emit_ff == EW'(MAX_RESULTS - 1));
      end else begin
         last = (rep_ff == head_cmd.rep);
      end
   end

   always_comb begin
      rep_in    = rep_ff;
      done_in   = done_ff;
      emit_in   = emit_ff;
      pop       = 1'b0;
      action_in = action_ff;
      char_in   = char_ff;
      hl_in     = hl_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         last_in  = last;
         pop      = last;
         if (head_cmd.colour) begin
            char_in = 8'd0;
            hl_in   = 1'b0;
            b_in    = 17'sd0;
            if (sel_val == 16'd0) begin
               action_in = ACT_RESET_COLOR;
               a_in      = 17'sd0;
            end else begin
               action_in = (sel_val < BG_BASE) ? ACT_FG : ACT_BG;
               a_in      = $signed({14'd0, color});
            end
            done_in = last ? '0 : (done_ff | pick);
            emit_in = last ? '0 : emit_ff + EW'(1);
         end else begin
            action_in = head_cmd.action;
            char_in   = head_cmd.char_code;
            hl_in     = head_cmd.highlight;
            a_in      = head_cmd.value_a;
            b_in      = head_cmd.value_b;
            rep_in    = last ? 2'd0 : rep_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      char_ff   <= char_in;
      hl_ff     <= hl_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rep_ff   <= '0;
         done_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rep_ff   <= rep_in;
         done_ff  <= done_in;
         emit_ff  <= emit_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_action    = action_ff;
   assign rsp_char_code = char_ff;
   assign rsp_highlight = hl_ff;
   assign rsp_value_a   = a_ff;
   assign rsp_value_b   = b_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

>>> rtl/core/terminal_escape_sequence_parser.sv
// Top level of the terminal escape sequence parser.
// The parser takes one output byte per cycle while req_stall is low and turns it into display
// commands on the rsp_ channel: a byte is classified in the cycle it is accepted and queued
// as at most one command, and the back part sends one result transfer per cycle while
// rsp_stall is low. A plain byte gives one result, a tab four, and an 'm' sequence one per
// stored colour parameter, at most eight, so bytes with at most one result flow at one byte
// per cycle, and a byte with more results holds the back part until all are sent. The first
// result passes the command queue and the result registers. The two-entry queue lets bytes
// without results (escape, digits, separators) keep coming while a longer command drains.
`timescale 1ns / 1ps
`default_nettype none

module terminal_escape_sequence_parser import tesp_pkg::*; #(
   parameter int MAX_PARAMS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_byte_in,
   input  wire logic               req_error_stream,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_action,
   output logic [7:0]              rsp_char_code,
   output logic                    rsp_highlight,
   output logic signed [16:0]      rsp_value_a,
   output logic signed [16:0]      rsp_value_b,
   output logic                    rsp_last
);

   localparam int QW = $bits(cmd_type) + MAX_PARAMS + MAX_PARAMS * 16;

   logic                         accept;
   logic                         job_valid;
   cmd_type                      job_cmd, head_cmd;
   logic [MAX_PARAMS-1:0]        job_mask, head_mask;
   logic [MAX_PARAMS-1:0][15:0]  job_vals, head_vals;
   logic [QW-1:0]                head;
   logic                         q_not_empty, q_full, pop;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   tesp_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_in      (req_byte_in),
      .error_stream (req_error_stream),
      .job_valid    (job_valid),
      .job_cmd      (job_cmd),
      .job_mask     (job_mask),
      .job_vals     (job_vals)
   );

   tesp_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_data ({job_cmd, job_mask, job_vals}),
      .pop       (pop),
      .head      (head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   assign {head_cmd, head_mask, head_vals} = head;

   tesp_back #(.MAX_PARAMS(MAX_PARAMS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (q_not_empty),
      .head_cmd      (head_cmd),
      .head_mask     (head_mask),
      .head_vals     (head_vals),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_action    (rsp_action),
      .rsp_char_code (rsp_char_code),
      .rsp_highlight (rsp_highlight),
      .rsp_value_a   (rsp_value_a),
      .rsp_value_b   (rsp_value_b),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

>>> rtl/core/tesp_checker.sv
// Port-level assertions for the terminal escape sequence parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module tesp_checker import tesp_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [3:0]         rsp_action,
   input wire logic [7:0]         rsp_char_code,
   input wire logic               rsp_highlight,
   input wire logic signed [16:0] rsp_value_a,
   input wire logic signed [16:0] rsp_value_b,
   input wire logic               rsp_last
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result does not change.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_action) && $stable(rsp_char_code) &&
         $stable(rsp_highlight) && $stable(rsp_value_a) && $stable(rsp_value_b) &&
         $stable(rsp_last))
      else $error("stalled result changed");

   // Highlighting belongs to character writes only.
   a_hl_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_highlight |-> rsp_action == ACT_WRITE_CHAR)
      else $error("highlight on a non-character result");

   // Colour results carry an index of eight colours and nothing else.
   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_FG || rsp_action == ACT_BG) |->
         rsp_value_a >= 17'sd0 && rsp_value_a <= 17'sd7 && rsp_value_b == 17'sd0 &&
         rsp_char_code == 8'd0)
      else $error("colour result out of range");

   // Reset leaves no result on offer.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind terminal_escape_sequence_parser tesp_checker u_tesp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_action    (rsp_action),
   .rsp_char_code (rsp_char_code),
   .rsp_highlight (rsp_highlight),
   .rsp_value_a   (rsp_value_a),
   .rsp_value_b   (rsp_value_b),
   .rsp_last      (rsp_last)
);

`default_nettype wire
